// ===== hw/rtl/dwsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Depth window sphere gate: shared types and constants
// Image size, queue sizing, register indexes, configuration and payload
// structures used by all the modules of the gate.
// ----------------------------------------------------------------------------
package dwsg_pkg;

   localparam int IMAGE_WIDTH  = 1024;
   localparam int IMAGE_HEIGHT = 1024;

   localparam int MIN_COL_W = $clog2(IMAGE_WIDTH + 1);
   localparam int MIN_ROW_W = $clog2(IMAGE_HEIGHT + 1);

   localparam int COUNT_W = 21;
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(1 << 20);

   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 34;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRINCIPAL_X,
      CSR_PRINCIPAL_Y,
      CSR_INV_FOCAL_X,
      CSR_INV_FOCAL_Y,
      CSR_TARGET_X,
      CSR_TARGET_Y,
      CSR_TARGET_Z,
      CSR_MAX_SQ_ERROR
   } csr_index_type;

   typedef struct packed {
      logic [13:0]        principal_x;
      logic [13:0]        principal_y;
      logic [23:0]        inv_focal_x;
      logic [23:0]        inv_focal_y;
      logic signed [16:0] target_x;
      logic signed [16:0] target_y;
      logic [15:0]        target_z;
      logic [33:0]        max_sq_error;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      principal_x:  14'd8192,
      principal_y:  14'd8192,
      inv_focal_x:  24'd27962,
      inv_focal_y:  24'd27962,
      target_x:     17'sd0,
      target_y:     17'sd0,
      target_z:     16'd1000,
      max_sq_error: 34'd250000
   };

   typedef struct packed {
      logic [9:0]  pixel_column;
      logic [9:0]  pixel_row;
      logic [15:0] depth_mm;
      logic        last_pixel;
   } req_type;

   typedef struct packed {
      logic [15:0]        depth_out;
      logic               hit;
      logic               summary_valid;
      logic [COUNT_W-1:0] hit_count;
      logic [10:0]        box_left;
      logic [10:0]        box_top;
      logic [9:0]         box_right;
      logic [9:0]         box_bottom;
   } rsp_type;

   typedef struct packed {
      logic    hit;
      req_type pix;
   } cls_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/dwsg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Depth window sphere gate: front end
// Accepts pixels against a credit count, back-projects them in a six-stage
// pipeline and classifies each as a hit or not before writing it to the queue.
// ----------------------------------------------------------------------------
module dwsg_front import dwsg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    q_pop,
   output logic    q_push,
   output cls_type q_item
);

   localparam int STAGES = 6;
   localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);

   logic             accept;
   logic [OCC_W-1:0] occ_ff, occ_in;

   logic    vld_ff   [STAGES];
   logic    vld_in   [STAGES];
   logic    inimg_ff [STAGES];
   logic    inimg_in [STAGES];
   req_type pix_ff   [STAGES];
   req_type pix_in   [STAGES];

   logic [9:0]         coord     [2];
   logic [13:0]        principal [2];
   logic [23:0]        inv       [2];
   logic signed [16:0] tgt       [2];

   logic signed [14:0] diff  [2];
   logic [14:0]        mag_a [2];
   logic signed [26:0] pos_d [2];
   logic signed [27:0] err_d [2];
   logic signed [16:0] err_z;

   logic               neg_a_ff  [2];
   logic               neg_a_in  [2];
   logic [29:0]        prod_a_ff [2];
   logic [29:0]        prod_a_in [2];
   logic               neg_b_ff  [2];
   logic               neg_b_in  [2];
   logic [53:0]        prod_b_ff [2];
   logic [53:0]        prod_b_in [2];
   logic signed [54:0] sgn_c_ff  [2];
   logic signed [54:0] sgn_c_in  [2];
   logic [27:0]        mag_d_ff  [2];
   logic [27:0]        mag_d_in  [2];
   logic [15:0]        magz_d_ff, magz_d_in;
   logic [55:0]        sq_e_ff   [2];
   logic [55:0]        sq_e_in   [2];
   logic [31:0]        sqz_e_ff, sqz_e_in;
   logic [57:0]        sum_f_ff, sum_f_in;

   assign coord[0]     = req_data.pixel_column;
   assign coord[1]     = req_data.pixel_row;
   assign principal[0] = cfg.principal_x;
   assign principal[1] = cfg.principal_y;
   assign inv[0]       = cfg.inv_focal_x;
   assign inv[1]       = cfg.inv_focal_y;
   assign tgt[0]       = cfg.target_x;
   assign tgt[1]       = cfg.target_y;

   assign req_ready = (occ_ff < OCC_W'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;

   always_comb begin
      occ_in = occ_ff + OCC_W'(accept) - OCC_W'(q_pop);

      vld_in[0]   = accept;
      pix_in[0]   = req_data;
      inimg_in[0] = (32'(req_data.pixel_column) < 32'(IMAGE_WIDTH)) &&
                    (32'(req_data.pixel_row) < 32'(IMAGE_HEIGHT));
      for (int s = 1; s < STAGES; s++) begin
         vld_in[s]   = vld_ff[s-1];
         pix_in[s]   = pix_ff[s-1];
         inimg_in[s] = inimg_ff[s-1];
      end

      for (int l = 0; l < 2; l++) begin
         diff[l]      = $signed({1'b0, coord[l], 4'b0000}) - $signed({1'b0, principal[l]});
         mag_a[l]     = diff[l][14] ? 15'(-diff[l]) : 15'(diff[l]);
         neg_a_in[l]  = diff[l][14];
         prod_a_in[l] = 30'(mag_a[l][13:0]) * 30'(req_data.depth_mm);

         neg_b_in[l]  = neg_a_ff[l];
         prod_b_in[l] = 54'(prod_a_ff[l]) * 54'(inv[l]);

         sgn_c_in[l] = neg_b_ff[l] ? -$signed({1'b0, prod_b_ff[l]})
                                   : $signed({1'b0, prod_b_ff[l]});

         pos_d[l]    = 27'(sgn_c_ff[l] >>> 28);
         err_d[l]    = $signed({pos_d[l][26], pos_d[l]}) -
                       $signed({{11{tgt[l][16]}}, tgt[l]});
         mag_d_in[l] = err_d[l][27] ? 28'(-err_d[l]) : 28'(err_d[l]);

         sq_e_in[l] = 56'(mag_d_ff[l]) * 56'(mag_d_ff[l]);
      end

      err_z     = $signed({1'b0, pix_ff[2].depth_mm}) - $signed({1'b0, cfg.target_z});
      magz_d_in = err_z[16] ? 16'(-err_z) : err_z[15:0];
      sqz_e_in  = 32'(magz_d_ff) * 32'(magz_d_ff);
      sum_f_in  = 58'(sq_e_ff[0]) + 58'(sq_e_ff[1]) + 58'(sqz_e_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         for (int s = 0; s < STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         occ_ff <= occ_in;
         for (int s = 0; s < STAGES; s++) begin
            vld_ff[s] <= vld_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         pix_ff[s]   <= pix_in[s];
         inimg_ff[s] <= inimg_in[s];
      end
      for (int l = 0; l < 2; l++) begin
         neg_a_ff[l]  <= neg_a_in[l];
         prod_a_ff[l] <= prod_a_in[l];
         neg_b_ff[l]  <= neg_b_in[l];
         prod_b_ff[l] <= prod_b_in[l];
         sgn_c_ff[l]  <= sgn_c_in[l];
         mag_d_ff[l]  <= mag_d_in[l];
         sq_e_ff[l]   <= sq_e_in[l];
      end
      magz_d_ff <= magz_d_in;
      sqz_e_ff  <= sqz_e_in;
      sum_f_ff  <= sum_f_in;
   end

   assign q_push     = vld_ff[STAGES-1];
   assign q_item.pix = pix_ff[STAGES-1];
   assign q_item.hit = inimg_ff[STAGES-1] && (sum_f_ff < 58'(cfg.max_sq_error));

endmodule
`default_nettype wire

// ===== hw/rtl/dwsg_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Depth window sphere gate: classified pixel queue
// First-in first-out buffer that decouples the projection pipeline from the
// accumulator and result register.
// ----------------------------------------------------------------------------
module dwsg_queue import dwsg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cls_type    push_item,
   input  logic       pop,
   output cls_type    head,
   output q_stat_type stat
);

   cls_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in;
   logic [QUEUE_AW-1:0] rd_ff, rd_in;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign head       = mem_ff[rd_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));

endmodule
`default_nettype wire

// ===== hw/rtl/dwsg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Depth window sphere gate: back end
// Takes classified pixels from the queue, keeps the hit count and bounding
// box of the window and holds each result in the output register.
// ----------------------------------------------------------------------------
module dwsg_back import dwsg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_stat_type q_stat,
   input  cls_type    q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic [COUNT_W-1:0]   hits_ff, hits_in, hits_new;
   logic [MIN_COL_W-1:0] min_col_ff, min_col_in, min_col_new;
   logic [MIN_ROW_W-1:0] min_row_ff, min_row_in, min_row_new;
   logic [9:0]           max_col_ff, max_col_in, max_col_new;
   logic [9:0]           max_row_ff, max_row_in, max_row_new;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in, rsp_new;

   assign q_pop = !q_stat.empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      hits_new    = hits_ff;
      min_col_new = min_col_ff;
      min_row_new = min_row_ff;
      max_col_new = max_col_ff;
      max_row_new = max_row_ff;
      if (q_head.hit) begin
         if (hits_ff < COUNT_MAX) begin
            hits_new = hits_ff + 1'b1;
         end
         if (32'(q_head.pix.pixel_column) < 32'(min_col_ff)) begin
            min_col_new = MIN_COL_W'(q_head.pix.pixel_column);
         end
         if (32'(q_head.pix.pixel_row) < 32'(min_row_ff)) begin
            min_row_new = MIN_ROW_W'(q_head.pix.pixel_row);
         end
         if (q_head.pix.pixel_column > max_col_ff) begin
            max_col_new = q_head.pix.pixel_column;
         end
         if (q_head.pix.pixel_row > max_row_ff) begin
            max_row_new = q_head.pix.pixel_row;
         end
      end

      rsp_new               = '0;
      rsp_new.depth_out     = q_head.hit ? '0 : q_head.pix.depth_mm;
      rsp_new.hit           = q_head.hit;
      rsp_new.summary_valid = q_head.pix.last_pixel;
      if (q_head.pix.last_pixel) begin
         rsp_new.hit_count  = hits_new;
         rsp_new.box_left   = 11'(min_col_new);
         rsp_new.box_top    = 11'(min_row_new);
         rsp_new.box_right  = max_col_new;
         rsp_new.box_bottom = max_row_new;
      end

      hits_in    = hits_ff;
      min_col_in = min_col_ff;
      min_row_in = min_row_ff;
      max_col_in = max_col_ff;
      max_row_in = max_row_ff;
      if (q_pop) begin
         if (q_head.pix.last_pixel) begin
            hits_in    = '0;
            min_col_in = MIN_COL_W'(IMAGE_WIDTH);
            min_row_in = MIN_ROW_W'(IMAGE_HEIGHT);
            max_col_in = '0;
            max_row_in = '0;
         end else begin
            hits_in    = hits_new;
            min_col_in = min_col_new;
            min_row_in = min_row_new;
            max_col_in = max_col_new;
            max_row_in = max_row_new;
         end
      end

      priority if (q_pop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_new;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
         rsp_data_in  = rsp_data_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff      <= '0;
         min_col_ff   <= MIN_COL_W'(IMAGE_WIDTH);
         min_row_ff   <= MIN_ROW_W'(IMAGE_HEIGHT);
         max_col_ff   <= '0;
         max_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hits_ff      <= hits_in;
         min_col_ff   <= min_col_in;
         min_row_ff   <= min_row_in;
         max_col_ff   <= max_col_in;
         max_row_ff   <= max_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/depth_window_sphere_gate_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Depth window sphere gate: top level
// Back-projects depth pixels of a search window, gates them against a sphere
// round the target point, and reports hit count and bounding box per window.
//
//   Port group   Direction  Handshake         Payload
//   req_*        in         valid / ready     req_type (column, row, depth, last)
//   rsp_*        out        valid / ready     rsp_type (depth, hit, summary)
//   csr_*        in         write enable      register index and write data
//
// One pixel is taken every cycle while results are drained every cycle.
// A pixel's result passes through six projection stages, the first loaded by
// the transfer itself, then the queue write and the result register, which is
// loaded together with the window accumulators when the queue head is popped.
// Sixteen credits cover the pipeline and queue, so input stalls only when
// the result side has been held back long enough to fill them.
// Reset restores the registers, empties the pipeline and queue and clears the
// window accumulators.
// ----------------------------------------------------------------------------
module depth_window_sphere_gate_top import dwsg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       q_push;
   logic       q_pop;
   cls_type    q_item;
   cls_type    q_head;
   q_stat_type q_stat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRINCIPAL_X:  cfg_in.principal_x  = csr_wdata[13:0];
            CSR_PRINCIPAL_Y:  cfg_in.principal_y  = csr_wdata[13:0];
            CSR_INV_FOCAL_X:  cfg_in.inv_focal_x  = csr_wdata[23:0];
            CSR_INV_FOCAL_Y:  cfg_in.inv_focal_y  = csr_wdata[23:0];
            CSR_TARGET_X:     cfg_in.target_x     = $signed(csr_wdata[16:0]);
            CSR_TARGET_Y:     cfg_in.target_y     = $signed(csr_wdata[16:0]);
            CSR_TARGET_Z:     cfg_in.target_z     = csr_wdata[15:0];
            CSR_MAX_SQ_ERROR: cfg_in.max_sq_error = csr_wdata[33:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dwsg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_pop     (q_pop),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   dwsg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   dwsg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (!q_stat.full || q_pop))
      else $error("Queue written while full.");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && req_ready))
      else $error("Block not idle after reset.");

   a_empty_window_box: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.summary_valid && (rsp_data.hit_count == '0)) |->
      ((rsp_data.box_left == 11'(IMAGE_WIDTH)) && (rsp_data.box_top == 11'(IMAGE_HEIGHT)) &&
       (rsp_data.box_right == '0) && (rsp_data.box_bottom == '0)))
      else $error("Window without hits reported a non-empty box.");
`endif

endmodule
`default_nettype wire

// ===== sim/depth_window_sphere_gate_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth window sphere gate: self-checking testbench
// Streams depth pixels into the gate under several camera and target
// settings, predicts the gated depth, the hit flag and the per-window hit
// count and bounding box, and compares every result transfer with the
// oldest prediction. Directed pixels probe the sphere boundary, the register
// extremes and empty windows; random windows of random length follow.
// ----------------------------------------------------------------------------
import dwsg_pkg::*;

function automatic longint back_project(longint diff, longint depth, longint inv);
   return (diff * depth * inv) >>> 28;
endfunction

class sphere_gate_scoreboard;
   localparam int REPORT_LIMIT = 100;

   cfg_type              cfg;
   logic [COUNT_W-1:0]   hits_so_far;
   logic [MIN_COL_W-1:0] min_column;
   logic [MIN_ROW_W-1:0] min_row;
   logic [9:0]           max_column;
   logic [9:0]           max_row;
   rsp_type              expected_pixels[$];
   int                   mismatches;

   function new();
      cfg = CFG_RESET;
      mismatches = 0;
      clear_window();
   endfunction

   function void clear_window();
      hits_so_far = '0;
      min_column  = MIN_COL_W'(IMAGE_WIDTH);
      min_row     = MIN_ROW_W'(IMAGE_HEIGHT);
      max_column  = '0;
      max_row     = '0;
   endfunction

   function void set_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_PRINCIPAL_X:  cfg.principal_x  = value[13:0];
         CSR_PRINCIPAL_Y:  cfg.principal_y  = value[13:0];
         CSR_INV_FOCAL_X:  cfg.inv_focal_x  = value[23:0];
         CSR_INV_FOCAL_Y:  cfg.inv_focal_y  = value[23:0];
         CSR_TARGET_X:     cfg.target_x     = value[16:0];
         CSR_TARGET_Y:     cfg.target_y     = value[16:0];
         CSR_TARGET_Z:     cfg.target_z     = value[15:0];
         CSR_MAX_SQ_ERROR: cfg.max_sq_error = value[33:0];
         default: ;
      endcase
   endfunction

   function void predict_pixel(req_type pix);
      longint  du, dv, dx, dy, dz, sq;
      logic    hit;
      rsp_type want;
      du = longint'(pix.pixel_column) * 16 - longint'(cfg.principal_x);
      dv = longint'(pix.pixel_row) * 16 - longint'(cfg.principal_y);
      dx = back_project(du, longint'(pix.depth_mm), longint'(cfg.inv_focal_x))
         - longint'($signed(cfg.target_x));
      dy = back_project(dv, longint'(pix.depth_mm), longint'(cfg.inv_focal_y))
         - longint'($signed(cfg.target_y));
      dz = longint'(pix.depth_mm) - longint'(cfg.target_z);
      sq = dx * dx + dy * dy + dz * dz;
      hit = pix.pixel_column < IMAGE_WIDTH && pix.pixel_row < IMAGE_HEIGHT
         && sq < longint'(cfg.max_sq_error);
      if (hit) begin
         if (hits_so_far < COUNT_MAX) hits_so_far++;
         if (pix.pixel_column < min_column) min_column = MIN_COL_W'(pix.pixel_column);
         if (pix.pixel_row < min_row) min_row = MIN_ROW_W'(pix.pixel_row);
         if (pix.pixel_column > max_column) max_column = pix.pixel_column;
         if (pix.pixel_row > max_row) max_row = pix.pixel_row;
      end
      want = '0;
      want.depth_out     = hit ? '0 : pix.depth_mm;
      want.hit           = hit;
      want.summary_valid = pix.last_pixel;
      if (pix.last_pixel) begin
         want.hit_count  = hits_so_far;
         want.box_left   = min_column;
         want.box_top    = min_row;
         want.box_right  = max_column;
         want.box_bottom = max_row;
         clear_window();
      end
      expected_pixels = {expected_pixels, want};
   endfunction

   task report(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endtask

   task check_pixel_result(rsp_type got);
      rsp_type want;
      if (expected_pixels.size() == 0) begin
         report($sformatf("result transfer with nothing expected: %h", got));
         return;
      end
      want = expected_pixels.pop_front();
      if (got.depth_out !== want.depth_out)
         report($sformatf("depth_out %0d, expected %0d", got.depth_out, want.depth_out));
      if (got.hit !== want.hit)
         report($sformatf("hit %0d, expected %0d", got.hit, want.hit));
      if (got.summary_valid !== want.summary_valid)
         report($sformatf("summary_valid %0d, expected %0d",
                          got.summary_valid, want.summary_valid));
      if (got.hit_count !== want.hit_count)
         report($sformatf("hit_count %0d, expected %0d", got.hit_count, want.hit_count));
      if (got.box_left !== want.box_left)
         report($sformatf("box_left %0d, expected %0d", got.box_left, want.box_left));
      if (got.box_top !== want.box_top)
         report($sformatf("box_top %0d, expected %0d", got.box_top, want.box_top));
      if (got.box_right !== want.box_right)
         report($sformatf("box_right %0d, expected %0d", got.box_right, want.box_right));
      if (got.box_bottom !== want.box_bottom)
         report($sformatf("box_bottom %0d, expected %0d",
                          got.box_bottom, want.box_bottom));
   endtask
endclass

module depth_window_sphere_gate_top_tb;
   localparam int WINDOW_MAX   = 48;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_PIXELS = 190;
   localparam int QUIET_PHASE  = 3;
   localparam int IDLE_PERCENT = 33;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 24;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bit                     idling = 1'b1;
   int                     center_column;
   int                     center_row;
   int                     center_depth;
   sphere_gate_scoreboard  scoreboard = new();

   depth_window_sphere_gate_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) scoreboard.check_pixel_result(rsp_data);
         rsp_ready <= !idling || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic send_pixel(input req_type pix);
      if (idling && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      req_valid <= 1'b1;
      req_data  <= pix;
      do @(posedge clock); while (!req_ready);
      scoreboard.predict_pixel(pix);
   endtask

   task automatic drain();
      int guard = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (scoreboard.expected_pixels.size() != 0 && guard < DRAIN_LIMIT);
      if (scoreboard.expected_pixels.size() != 0) begin
         scoreboard.report($sformatf("%0d results never arrived",
                                     scoreboard.expected_pixels.size()));
         scoreboard.expected_pixels.delete();
      end
   endtask

   task automatic apply_settings(input cfg_type c);
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] junk;
      logic [CSR_DATA_W-1:0] word;
      index = index.first();
      repeat (index.num()) begin
         junk = CSR_DATA_W'({$urandom, $urandom});
         if ($urandom_range(1)) junk = '0;
         case (index)
            CSR_PRINCIPAL_X: word = {junk[33:14], c.principal_x};
            CSR_PRINCIPAL_Y: word = {junk[33:14], c.principal_y};
            CSR_INV_FOCAL_X: word = {junk[33:24], c.inv_focal_x};
            CSR_INV_FOCAL_Y: word = {junk[33:24], c.inv_focal_y};
            CSR_TARGET_X:    word = {junk[33:17], c.target_x};
            CSR_TARGET_Y:    word = {junk[33:17], c.target_y};
            CSR_TARGET_Z:    word = {junk[33:16], c.target_z};
            default:         word = c.max_sq_error;
         endcase
         csr_we    <= 1'b1;
         csr_index <= index;
         csr_wdata <= word;
         @(posedge clock);
         scoreboard.set_register(index, word);
         index = index.next();
      end
      csr_we <= 1'b0;
   endtask

   function automatic req_type random_pixel(input bit near, input bit last);
      req_type pix;
      int      depth;
      if (near) begin
         pix.pixel_column = 10'(center_column + $urandom_range(16) - 8);
         pix.pixel_row    = 10'(center_row + $urandom_range(16) - 8);
         depth = center_depth + int'($urandom_range(600)) - 300;
         if (depth < 0) depth = 0;
         if (depth > 65535) depth = 65535;
         pix.depth_mm = 16'(depth);
      end else begin
         pix.pixel_column = 10'($urandom);
         pix.pixel_row    = 10'($urandom);
         pix.depth_mm     = 16'($urandom);
      end
      pix.last_pixel = last;
      return pix;
   endfunction

   initial begin
      cfg_type settings;
      longint  tx;
      longint  ty;
      int      radius;
      int      window_left;
      bit      last;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register values from reset: gate of radius 500 mm round (0, 0, 1000).
      send_pixel('{10'd512, 10'd512, 16'd1000, 1'b0});
      send_pixel('{10'd520, 10'd500, 16'd1200, 1'b0});
      send_pixel('{10'd512, 10'd512, 16'd500, 1'b0});
      send_pixel('{10'd512, 10'd512, 16'd1500, 1'b0});
      send_pixel('{10'd512, 10'd512, 16'd501, 1'b0});
      send_pixel('{10'd0, 10'd0, 16'd0, 1'b0});
      send_pixel('{10'd1023, 10'd1023, 16'd65535, 1'b0});
      send_pixel('{10'd600, 10'd400, 16'd900, 1'b1});
      send_pixel('{10'd0, 10'd0, 16'd0, 1'b1});
      send_pixel('{10'd1023, 10'd0, 16'd1000, 1'b1});

      drain();
      apply_settings('{14'd0, 14'd0, 24'd1, 24'd1, 17'h10000, 17'h10000, 16'd0, 34'd0});
      send_pixel('{10'd0, 10'd0, 16'd0, 1'b0});
      send_pixel('{10'd1023, 10'd1023, 16'd65535, 1'b0});
      send_pixel('{10'd0, 10'd0, 16'd0, 1'b1});

      drain();
      apply_settings('{14'h3FFF, 14'h3FFF, 24'hFFFFFF, 24'hFFFFFF, 17'h0FFFF, 17'h0FFFF,
                       16'hFFFF, 34'h3_FFFF_FFFF});
      send_pixel('{10'd0, 10'd0, 16'd0, 1'b0});
      send_pixel('{10'd1023, 10'd1023, 16'd65535, 1'b0});
      send_pixel('{10'd1023, 10'd0, 16'd65535, 1'b0});
      send_pixel('{10'd0, 10'd1023, 16'd1, 1'b1});

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         settings.principal_x = 14'($urandom);
         settings.principal_y = 14'($urandom);
         settings.inv_focal_x = 24'(($urandom_range(24'hFFFFFF, 1) >> $urandom_range(16, 4)) | 1);
         settings.inv_focal_y = 24'(($urandom_range(24'hFFFFFF, 1) >> $urandom_range(16, 4)) | 1);
         center_column = $urandom_range(1023);
         center_row    = $urandom_range(1023);
         center_depth  = $urandom_range(20000, 200);
         tx = back_project(longint'(center_column) * 16 - longint'(settings.principal_x),
                           longint'(center_depth), longint'(settings.inv_focal_x));
         ty = back_project(longint'(center_row) * 16 - longint'(settings.principal_y),
                           longint'(center_depth), longint'(settings.inv_focal_y));
         if (tx > 65535) tx = 65535;
         if (tx < -65536) tx = -65536;
         if (ty > 65535) ty = 65535;
         if (ty < -65536) ty = -65536;
         settings.target_x = 17'(tx);
         settings.target_y = 17'(ty);
         settings.target_z = 16'(center_depth + int'($urandom_range(200)) - 100);
         radius = $urandom_range(3000, 20);
         settings.max_sq_error = 34'(longint'(radius) * radius);
         apply_settings(settings);
         idling = (phase != QUIET_PHASE);
         window_left = $urandom_range(WINDOW_MAX, 1);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            window_left--;
            last = window_left == 0 || n == PHASE_PIXELS - 1 || $urandom_range(99) < 3;
            send_pixel(random_pixel($urandom_range(99) < 55, last));
            if (last) window_left = $urandom_range(WINDOW_MAX, 1);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (scoreboard.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ===== depth_window_sphere_gate_top.f =====
hw/rtl/dwsg_pkg.sv
hw/rtl/dwsg_front.sv
hw/rtl/dwsg_queue.sv
hw/rtl/dwsg_back.sv
hw/rtl/depth_window_sphere_gate_top.sv
sim/depth_window_sphere_gate_top_tb.sv
